// File: rtl/sequential_list_engine_defines.svh
// Assertion macros used by the list engine controller (sle_ctrl).
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sle_pkg.sv
package sle_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_DELETE = 3'd1;
	localparam logic [2:0] KIND_LOCATE = 3'd2;
	localparam logic [2:0] KIND_GET    = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_BAD_INDEX = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_SHIFT
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [4:0]  idx;
	} cell_ctl_t;

endpackage

// File: rtl/sle_cell.sv
module sle_cell #(
	parameter int WORD_BITS = 32,
	parameter int POS       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sle_pkg::cell_ctl_t    ctl,
	input  logic [WORD_BITS-1:0]  ins_word,
	input  logic [WORD_BITS-1:0]  left,
	input  logic [WORD_BITS-1:0]  right,
	output logic [WORD_BITS-1:0]  word
);
	import sle_pkg::*;

	logic [WORD_BITS-1:0] word_q;

	// Insert pulls from the lower neighbor above the insert point; delete and
	// rotate pull from the upper neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			case (ctl.op)
				CELL_INSERT: begin
					if (POS > int'(ctl.idx)) begin
						word_q <= left;
					end else if (POS == int'(ctl.idx)) begin
						word_q <= ins_word;
					end
				end
				CELL_DELETE: begin
					if (POS >= int'(ctl.idx)) begin
						word_q <= right;
					end
				end
				CELL_ROTATE: word_q <= right;
				CELL_CLEAR:  word_q <= '0;
				default: ;
			endcase
		end
	end

	assign word = word_q;

endmodule

// File: rtl/sle_ctrl.sv
`include "sequential_list_engine_defines.svh"

module sle_ctrl #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            kind,
	input  logic [4:0]            index,
	input  logic signed [31:0]    value,
	input  logic [WORD_BITS-1:0]  cell0,
	output logic                  busy,
	output sle_pkg::cell_ctl_t    ctl,
	output logic [WORD_BITS-1:0]  ins_word,
	output logic                  done,
	output logic [2:0]            status,
	output logic signed [31:0]    data,
	output logic [3:0]            position,
	output logic [4:0]            count
);
	import sle_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int UW = $clog2(DEPTH + 1);

	state_t               state_q, state_d;
	logic [UW-1:0]        used_q;
	logic [SW-1:0]        step_q;
	logic                 done_q;
	logic [2:0]           kind_q;
	logic [4:0]           idx_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 found_q;
	logic [2:0]           status_q;
	logic signed [31:0]   data_q;
	logic [3:0]           pos_q;
	logic [UW-1:0]        count_q;

	logic                 accept;
	logic                 last_step;
	logic                 scan_go;
	logic [2:0]           imm_status;
	logic [UW-1:0]        imm_count;

	assign ins_word  = WORD_BITS'(value);
	assign accept    = start & ~busy;
	assign last_step = (step_q == SW'(DEPTH - 1));

	// Checks made on the incoming transaction; scan_go marks the ones that
	// need a full rotation of the chain.
	always_comb begin
		scan_go    = 1'b0;
		imm_status = STAT_OK;
		imm_count  = used_q;
		case (kind)
			KIND_INSERT: begin
				if (used_q == UW'(DEPTH)) begin
					imm_status = STAT_FULL;
				end else if (int'(index) > int'(used_q)) begin
					imm_status = STAT_BAD_INDEX;
				end else begin
					imm_count = UW'(used_q + 1'b1);
				end
			end
			KIND_DELETE, KIND_GET: begin
				if (used_q == '0) begin
					imm_status = STAT_EMPTY;
				end else if (int'(index) >= int'(used_q)) begin
					imm_status = STAT_BAD_INDEX;
				end else begin
					scan_go = 1'b1;
				end
			end
			KIND_LOCATE: begin
				imm_status = STAT_NOT_FOUND;
				scan_go    = (used_q != '0);
			end
			KIND_CLEAR: imm_count = '0;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && scan_go) begin
					state_d = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				if (last_step) begin
					state_d = (kind_q == KIND_DELETE) ? ST_SHIFT : ST_IDLE;
				end
			end
			ST_SHIFT: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != ST_IDLE);
		ctl.op  = CELL_HOLD;
		ctl.idx = index;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_INSERT && imm_status == STAT_OK) begin
					ctl.op = CELL_INSERT;
				end else if (accept && kind == KIND_CLEAR) begin
					ctl.op = CELL_CLEAR;
				end
			end
			ST_ROTATE: ctl.op = CELL_ROTATE;
			ST_SHIFT: begin
				ctl.op  = CELL_DELETE;
				ctl.idx = idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !scan_go)
				|| (state_q == ST_ROTATE && last_step && kind_q != KIND_DELETE)
				|| (state_q == ST_SHIFT);
			if (accept) begin
				used_q <= imm_count;
				step_q <= '0;
			end else if (state_q == ST_ROTATE) begin
				step_q <= SW'(step_q + 1'b1);
			end else if (state_q == ST_SHIFT) begin
				used_q <= UW'(used_q - 1'b1);
			end
		end
	end

	// During the rotation cell 0 holds entry step_q.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			idx_q    <= index;
			word_q   <= ins_word;
			found_q  <= 1'b0;
			data_q   <= '0;
			pos_q    <= '0;
			status_q <= imm_status;
			count_q  <= imm_count;
		end else if (state_q == ST_ROTATE) begin
			if ((kind_q == KIND_GET || kind_q == KIND_DELETE)
				&& int'(step_q) == int'(idx_q)) begin
				data_q <= 32'(signed'(cell0));
			end
			if (kind_q == KIND_LOCATE && !found_q && int'(step_q) < int'(used_q)
				&& cell0 == word_q) begin
				found_q  <= 1'b1;
				status_q <= STAT_OK;
				pos_q    <= 4'(step_q);
			end
		end else if (state_q == ST_SHIFT) begin
			count_q <= UW'(used_q - 1'b1);
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data     = data_q;
	assign position = pos_q;
	assign count    = 5'(count_q);

	`SLE_ASSERT_NOW(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE, "result shown while busy")
	`SLE_ASSERT_NEXT(a_clear_empties, clk, arst_n, accept && kind == KIND_CLEAR, used_q == '0, "clear left entries")
	`SLE_ASSERT_NEXT(a_shift_drops_one, clk, arst_n, state_q == ST_SHIFT, used_q == UW'($past(used_q) - 1'b1), "delete count wrong")
	`SLE_ASSERT_NOW(a_used_bounded, clk, arst_n, 1'b1, int'(used_q) <= DEPTH, "entry count above depth")

endmodule

// File: rtl/sequential_list_engine.sv
// Insert, clear, unused kinds, rejected transactions and locate on an empty list: result
// shows in the cycle after start, and busy stays low, so the next start is taken. Other gets
// and locates show their result after one rotation of the chain past cell 0; delete adds a shift.
// busy is high from the cycle after a rotating transaction is taken until its result shows.
// done marks each result for one cycle and is never stalled.
// Reset (arst_n low) zeroes every entry and the internal entry count at once; no clearing pass is needed.
module sequential_list_engine #(
	parameter int DEPTH     = sle_pkg::DEPTH_DEF,
	parameter int WORD_BITS = sle_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          kind,
	input  logic [4:0]          index,
	input  logic signed [31:0]  value,
	output logic                done,
	output logic [2:0]          status,
	output logic signed [31:0]  data,
	output logic [3:0]          position,
	output logic [4:0]          count
);
	import sle_pkg::*;

	// The list lives in a row of cells, entry i in cell i. Entries at or
	// above the count are always zero, so a shift never needs to know the
	// count: insert moves everything above the insert point up by one, and
	// delete pulls everything from the delete point down by one, the top
	// cell taking zero.
	logic [WORD_BITS-1:0] cell_word [DEPTH];
	logic [WORD_BITS-1:0] ins_word;
	logic [WORD_BITS-1:0] top_right;
	cell_ctl_t            ctl;

	// Reads and searches rotate the whole chain once, cell 0 wrapping to the
	// top, so that the controller sees every entry at cell 0 in order; after
	// DEPTH steps the list is back in place.
	assign top_right = (ctl.op == CELL_ROTATE) ? cell_word[0] : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = top_right;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		sle_cell #(
			.WORD_BITS (WORD_BITS),
			.POS       (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ins_word (ins_word),
			.left     (left_w),
			.right    (right_w),
			.word     (cell_word[i])
		);
	end

	// The controller checks each transaction against the count, drives the
	// chain, watches cell 0 during a rotation and holds the result registers.
	sle_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.index    (index),
		.value    (value),
		.cell0    (cell_word[0]),
		.busy     (busy),
		.ctl      (ctl),
		.ins_word (ins_word),
		.done     (done),
		.status   (status),
		.data     (data),
		.position (position),
		.count    (count)
	);

endmodule
